FILE: hdl/avcc_pkg.sv
// shared types and constants for the avcc parameter set extractor
// no dependencies; imported by all hdl modules

package avcc_pkg;

    // parser phases
    typedef enum logic [2:0] {
        PH_SKIP    = 3'd0,
        PH_COUNT   = 3'd1,
        PH_SIZE_HI = 3'd2,
        PH_SIZE_LO = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_IDLE    = 3'd5
    } avcc_phase_t;

    // one classified item handed from the parser to the emitter
    typedef struct packed {
        logic       sc;    // expands to the four start code bytes
        logic       kind;  // 0 sps, 1 pps
        logic [7:0] data;  // payload byte when sc is low
    } avcc_item_t;

    localparam logic [7:0] HEADER_SKIP_RESET = 8'd13;
    localparam logic [7:0] SC_ZERO_BYTE      = 8'h00;
    localparam logic [7:0] SC_FINAL_BYTE     = 8'h01;
    localparam logic [1:0] SC_LAST_IDX       = 2'd3;
    localparam int unsigned QUEUE_DEPTH      = 2;

endpackage

FILE: hdl/avcc_parser.sv
// front end: walks the configuration box byte by byte and classifies bytes
// depends on avcc_pkg; pushes start code and payload items into the queue

module avcc_parser
    import avcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] header_skip,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       push,
    output avcc_item_t push_item
);

    avcc_phase_t phase_reg, phase_next;
    logic [7:0]  skip_count_reg, skip_count_next;
    logic [4:0]  units_left_reg, units_left_next;
    logic [7:0]  size_high_reg, size_high_next;
    logic [15:0] payload_left_reg, payload_left_next;
    logic        in_pps_reg, in_pps_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SKIP;
            skip_count_reg   <= '0;
            units_left_reg   <= '0;
            size_high_reg    <= '0;
            payload_left_reg <= '0;
            in_pps_reg       <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg        <= phase_next;
            skip_count_reg   <= skip_count_next;
            units_left_reg   <= units_left_next;
            size_high_reg    <= size_high_next;
            payload_left_reg <= payload_left_next;
            in_pps_reg       <= in_pps_next;
        end
    end

    // next state and classification of the current byte
    always_comb
    begin
        logic [15:0] size;
        logic [15:0] pl_dec;
        logic [4:0]  un;
        phase_next        = phase_reg;
        skip_count_next   = skip_count_reg;
        units_left_next   = units_left_reg;
        size_high_next    = size_high_reg;
        payload_left_next = payload_left_reg;
        in_pps_next       = in_pps_reg;
        push              = 1'b0;
        push_item.sc      = 1'b0;
        push_item.kind    = in_pps_reg;
        push_item.data    = in_byte;
        size              = {size_high_reg, in_byte};
        pl_dec            = payload_left_reg - 16'd1;
        un                = units_left_reg - 5'd1;

        unique case (phase_reg)
            PH_SKIP, PH_COUNT:
            begin
                if (phase_reg == PH_SKIP && skip_count_reg != header_skip)
                begin
                    skip_count_next = skip_count_reg + 8'd1;
                end
                else
                begin
                    // count byte: low five bits
                    units_left_next = in_byte[4:0];
                    if (in_byte[4:0] != 5'd0)
                        phase_next = PH_SIZE_HI;
                    else if (!in_pps_reg)
                    begin
                        in_pps_next = 1'b1;
                        phase_next  = PH_COUNT;
                    end
                    else
                        phase_next = PH_IDLE;
                end
            end
            PH_SIZE_HI:
            begin
                size_high_next = in_byte;
                phase_next     = PH_SIZE_LO;
            end
            PH_SIZE_LO:
            begin
                push            = in_accept;
                push_item.sc    = 1'b1;
                units_left_next = un;
                if (size != 16'd0)
                begin
                    payload_left_next = size;
                    phase_next        = PH_PAYLOAD;
                end
                else if (un != 5'd0)
                    phase_next = PH_SIZE_HI;
                else if (!in_pps_reg)
                begin
                    in_pps_next = 1'b1;
                    phase_next  = PH_COUNT;
                end
                else
                    phase_next = PH_IDLE;
            end
            PH_PAYLOAD:
            begin
                push              = in_accept;
                payload_left_next = pl_dec;
                if (pl_dec == 16'd0)
                begin
                    if (units_left_reg != 5'd0)
                        phase_next = PH_SIZE_HI;
                    else if (!in_pps_reg)
                    begin
                        in_pps_next = 1'b1;
                        phase_next  = PH_COUNT;
                    end
                    else
                        phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // box end rearms the parser
        if (in_end)
        begin
            phase_next        = PH_SKIP;
            skip_count_next   = '0;
            units_left_next   = '0;
            size_high_next    = '0;
            payload_left_next = '0;
            in_pps_next       = 1'b0;
        end
    end

endmodule

FILE: hdl/avcc_queue.sv
// short queue between parser and emitter
// depends on avcc_pkg for the item type and depth

module avcc_queue
    import avcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  avcc_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output avcc_item_t head_item
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    avcc_item_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_item;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_ONE;
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_ONE;
        end
    end

endmodule

FILE: hdl/avcc_emitter.sv
// back end: expands queue items into output bytes behind an output register
// depends on avcc_pkg

module avcc_emitter
    import avcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  avcc_item_t head_item,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [1:0] m_tuser,
    output logic       m_tlast
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] data_reg;
    logic [1:0] user_reg;
    logic       last_reg;
    logic       load;
    logic       sc_done;

    assign load    = head_valid && (!valid_reg || m_tready);
    assign sc_done = (idx_reg == SC_LAST_IDX);
    assign pop     = load && (!head_item.sc || sc_done);

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    // control: output valid and start code byte index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
                valid_reg <= 1'b1;
            else if (m_tready)
                valid_reg <= 1'b0;
            if (load && head_item.sc)
                idx_reg <= idx_reg + 2'd1;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (head_item.sc)
                data_reg <= sc_done ? SC_FINAL_BYTE : SC_ZERO_BYTE;
            else
                data_reg <= head_item.data;
            user_reg <= {head_item.kind, head_item.sc};
            last_reg <= !head_item.sc || sc_done;
        end
    end

endmodule

FILE: hdl/avcc_param_set_extract_top.sv
// top level of the avcc parameter set extractor
// depends on avcc_pkg, avcc_parser, avcc_queue, avcc_emitter
//
// usage:
//   s_* channel takes the configuration box one byte per transaction,
//   s_tlast marks the final byte of the box and rearms the parser.
//   m_* channel gives annex b bytes: each parameter set is preceded by
//   00 00 00 01 (m_tuser[0] high), m_tuser[1] tells sps (0) from pps (1),
//   m_tlast marks the last output byte caused by one input byte.
//   cfg_* writes header_skip (bytes before the sps count byte); always ready,
//   write it only while the block is idle.
// timing:
//   first output byte is offered on m_* once its item has passed the queue and the output register.
//   payload bytes pass at one per cycle while m_tready is high; the size-low
//   byte expands into four start code bytes that occupy the output register
//   in turn; the two-entry queue takes one more byte meanwhile, then s_tready
//   stays low until the last start code byte is loaded.
// reset: header_skip returns to 13, parser rearms, queue and output empty.
// stall: when m_tready is low the output holds, the queue fills and s_tready
//   drops once it is full; no byte is lost.

module avcc_param_set_extract_top
    import avcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // box_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] is_start_code, [1] unit_kind
    output logic       m_tlast,   // run_last
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data   // [7:0] header_skip
);

    logic [7:0] header_skip_reg;
    logic       in_accept;
    logic       push;
    avcc_item_t push_item;
    logic       full;
    logic       pop;
    logic       head_valid;
    avcc_item_t head_item;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            header_skip_reg <= HEADER_SKIP_RESET;
        else if (cfg_valid && cfg_ready)
            header_skip_reg <= cfg_data;
    end

    avcc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .header_skip (header_skip_reg),
        .in_accept   (in_accept),
        .in_byte     (s_tdata),
        .in_end      (s_tlast),
        .push        (push),
        .push_item   (push_item)
    );

    avcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    avcc_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: bench/tb_avcc_param_set_extract_top.sv
// testbench for avcc_param_set_extract_top: feeds configuration boxes byte by byte
// and checks every annex b output byte against an in-bench parser model
// depends on avcc_pkg and the avcc_param_set_extract_top hdl

module tb_avcc_param_set_extract_top;
    timeunit 1ns;
    timeprecision 1ps;

    import avcc_pkg::*;

    // box shapes the stimulus builder knows
    localparam int BOX_PLAIN = 0;
    localparam int BOX_CUT   = 1;
    localparam int BOX_NOISE = 2;
    localparam int BOX_MANY  = 3;

    localparam int SIDE_IN  = 0;
    localparam int SIDE_OUT = 1;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 120;
    localparam int HOLD_TRIGGER   = 40;

    // one input byte with its box-end mark
    typedef struct packed {
        logic [7:0] data;
        logic       box_end;
    } box_byte_t;

    // one expected annex b output byte
    typedef struct packed {
        logic [7:0] value;
        logic       sc;
        logic       kind;
        logic       last;
    } annexb_byte_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = 8'h00;

    box_byte_t    feed_q[$];
    annexb_byte_t annexb_expected[$];

    // parser model state
    avcc_phase_t ps_phase       = PH_SKIP;
    logic [7:0]  ps_skip        = 8'd0;
    logic [4:0]  ps_units       = 5'd0;
    logic [7:0]  ps_size_hi     = 8'd0;
    logic [15:0] ps_payload     = 16'd0;
    logic        ps_in_pps      = 1'b0;
    logic [7:0]  ps_header_skip = HEADER_SKIP_RESET;

    bit in_fire  = 1'b0;
    bit out_fire = 1'b0;
    bit hold_on  = 1'b0;
    int in_wait  = 0;
    int out_wait = 0;
    int stretch_left[2];
    bit fast_mode[2];

    int items_queued   = 0;
    int items_accepted = 0;
    int bytes_out      = 0;
    int boxes_built    = 0;
    int err_count      = 0;
    int idle_cycles    = 0;
    annexb_byte_t exp_b;
    box_byte_t    nxt_b;

    avcc_param_set_extract_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------
    function void emit(input logic [7:0] v, input logic sc, input logic last);
        annexb_expected.push_back({v, sc, ps_in_pps, last});
    endfunction

    // a finished sps list moves on to the pps count, a finished pps list ends the box
    function void close_list();
        if (!ps_in_pps)
        begin
            ps_in_pps = 1'b1;
            ps_phase  = PH_COUNT;
        end
        else
            ps_phase = PH_IDLE;
    endfunction

    function void next_unit();
        if (ps_units != 5'd0)
            ps_phase = PH_SIZE_HI;
        else
            close_list();
    endfunction

    // reserved top bits of the count byte are dropped
    function void take_count(input logic [7:0] b);
        ps_units = b[4:0];
        if (ps_units == 5'd0)
            close_list();
        else
            ps_phase = PH_SIZE_HI;
    endfunction

    function void parse_byte(input logic [7:0] b, input logic box_end);
        logic [15:0] sz;
        case (ps_phase)
            PH_SKIP:
            begin
                if (ps_skip == ps_header_skip)
                    take_count(b);
                else
                    ps_skip = ps_skip + 8'd1;
            end
            PH_COUNT:
                take_count(b);
            PH_SIZE_HI:
            begin
                ps_size_hi = b;
                ps_phase   = PH_SIZE_LO;
            end
            PH_SIZE_LO:
            begin
                sz = {ps_size_hi, b};
                emit(SC_ZERO_BYTE, 1'b1, 1'b0);
                emit(SC_ZERO_BYTE, 1'b1, 1'b0);
                emit(SC_ZERO_BYTE, 1'b1, 1'b0);
                emit(SC_FINAL_BYTE, 1'b1, 1'b1);
                ps_units = ps_units - 5'd1;
                if (sz == 16'd0)
                    next_unit();
                else
                begin
                    ps_payload = sz;
                    ps_phase   = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                emit(b, 1'b0, 1'b1);
                ps_payload = ps_payload - 16'd1;
                if (ps_payload == 16'd0)
                    next_unit();
            end
            default:
                ;
        endcase
        // box end rearms everything but header_skip
        if (box_end)
        begin
            ps_phase   = PH_SKIP;
            ps_skip    = 8'd0;
            ps_units   = 5'd0;
            ps_size_hi = 8'd0;
            ps_payload = 16'd0;
            ps_in_pps  = 1'b0;
        end
    endfunction

    function void check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    // wait per transaction, with stretches of back-to-back traffic
    function int draw_wait(input int side);
        if (stretch_left[side] == 0)
        begin
            stretch_left[side] = $urandom_range(6, 30);
            fast_mode[side]    = ($urandom_range(0, 2) == 0);
        end
        stretch_left[side]--;
        if (fast_mode[side])
            return 0;
        return $urandom_range(0, 11);
    endfunction

    // ------------------------------------------------------------------
    // sampling at the rising edge: check outputs, predict from inputs, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_fire  = rst_n && s_tvalid && s_tready;
        out_fire = rst_n && m_tvalid && m_tready;
        if (out_fire)
        begin
            bytes_out++;
            if (annexb_expected.size() == 0)
            begin
                $error("output transaction 0x%0h with nothing expected", m_tdata);
                err_count++;
            end
            else
            begin
                exp_b = annexb_expected.pop_front();
                check_field("out_byte", exp_b.value, m_tdata);
                check_field("is_start_code", {7'd0, exp_b.sc}, {7'd0, m_tuser[0]});
                check_field("unit_kind", {7'd0, exp_b.kind}, {7'd0, m_tuser[1]});
                check_field("run_last", {7'd0, exp_b.last}, {7'd0, m_tlast});
            end
        end
        if (in_fire)
        begin
            parse_byte(s_tdata, s_tlast);
            items_accepted++;
        end
        if (in_fire || out_fire || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_avcc_param_set_extract_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // input driver, fed from feed_q
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (in_fire)
            in_wait = draw_wait(SIDE_IN);
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (in_wait != 0)
            begin
                in_wait--;
                s_tvalid <= 1'b0;
            end
            else if (feed_q.size() != 0)
            begin
                nxt_b = feed_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt_b.data;
                s_tlast  <= nxt_b.box_end;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // output receiver: random ready gaps plus the long hold
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (out_fire)
            out_wait = draw_wait(SIDE_OUT);
        if (hold_on)
            m_tready <= 1'b0;
        else if (out_wait != 0)
        begin
            out_wait--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= rst_n;
    end

    // long receiver hold while the sender keeps offering bytes
    initial
    begin
        wait (items_accepted >= HOLD_TRIGGER);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task push_byte(input logic [7:0] d, input logic last);
        feed_q.push_back({d, last});
        items_queued++;
    endtask

    // wait until every byte is taken and every expected output has come
    task settle();
        @(negedge clk);
        while (items_accepted != items_queued || annexb_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task write_skip(input logic [7:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        ps_header_skip = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // build one box; useful counts the bytes past the header that were queued
    task automatic build_box(input int skip, input int style, output int useful);
        logic [7:0] bq[$];
        int n_units;
        int sz;
        int cut;
        int lst;
        int u;
        int i;
        bq = {};
        repeat (skip) bq.push_back(8'($urandom));
        if (style == BOX_NOISE)
        begin
            repeat ($urandom_range(1, 12)) bq.push_back(8'($urandom));
        end
        else
        begin
            for (lst = 0; lst < 2; lst++)
            begin
                if (style == BOX_MANY && lst == 0)
                    n_units = 31;
                else
                    n_units = $urandom_range(0, 3);
                // count byte with random reserved bits
                bq.push_back(8'($urandom & 32'he0) | 8'(n_units));
                for (u = 0; u < n_units; u++)
                begin
                    if (style == BOX_MANY)
                        sz = 0;
                    else
                        sz = $urandom_range(0, 6);
                    bq.push_back(8'(sz >> 8));
                    bq.push_back(8'(sz));
                    repeat (sz) bq.push_back(8'($urandom));
                end
            end
            repeat ($urandom_range(0, 3)) bq.push_back(8'($urandom));
        end
        cut = bq.size();
        if (style == BOX_CUT)
            cut = $urandom_range(1, bq.size());
        for (i = 0; i < cut; i++)
            push_byte(bq[i], i == cut - 1);
        useful = (cut > skip) ? cut - skip : 0;
        boxes_built++;
    endtask

    // one header_skip setting: opening box of a given shape, then random boxes
    task run_phase(input logic [7:0] skip, input int target, input int opener);
        int got;
        int useful;
        int r;
        int style;
        settle();
        write_skip(skip);
        @(posedge clk);
        build_box(skip, opener, useful);
        got = useful;
        while (got < target)
        begin
            r = $urandom_range(0, 9);
            style = (r < 7) ? BOX_PLAIN : (r < 9) ? BOX_CUT : BOX_NOISE;
            build_box(skip, style, useful);
            got += useful;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed boxes with a zero header skip
        write_skip(8'd0);
        @(posedge clk);
        // reserved count bits, payload extremes, empty pps list, ignored tail
        push_byte(8'he1, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h02, 1'b0);
        push_byte(8'hff, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'haa, 1'b0); push_byte(8'h55, 1'b1);
        // empty sps list, zero-size pps, box end on the last payload byte
        push_byte(8'h00, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
        push_byte(8'h80, 1'b1);
        // box ending inside a payload
        push_byte(8'h01, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h05, 1'b0);
        push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b1);
        // box ending on its count byte
        push_byte(8'h1f, 1'b1);
        // size with a nonzero high byte, box ends after three payload bytes
        push_byte(8'h01, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h02, 1'b0);
        push_byte(8'h3c, 1'b0); push_byte(8'hc3, 1'b0); push_byte(8'h7e, 1'b1);

        // random boxes over several header_skip settings
        run_phase(HEADER_SKIP_RESET, 0, BOX_MANY);
        run_phase(8'($urandom_range(1, 6)), 15, BOX_CUT);
        run_phase(8'($urandom_range(0, 3)), 10, BOX_NOISE);
        settle();

        if (annexb_expected.size() != 0)
        begin
            $error("%0d expected output bytes never arrived", annexb_expected.size());
            err_count++;
        end
        $display("run: %0d boxes, %0d input bytes, %0d output bytes checked",
                 boxes_built, items_accepted, bytes_out);
        $display("header_skip 0, 13 and small random values; one long output hold");
        if (err_count == 0)
            $display("tb_avcc_param_set_extract_top: clean");
        else
            $display("tb_avcc_param_set_extract_top: errors");
        $finish;
    end

endmodule
